FILE: rtl/core/qcr_pkg.sv
// Shared types and constants for the quarter-circle rasterizer.
package qcr_pkg;

  localparam int COORD_W     = 12;
  localparam int RADIUS_W    = 6;
  localparam int QUAD_W      = 3;
  localparam int COLOR_W     = 16;
  localparam int D_W         = 12;
  localparam int POS_W       = RADIUS_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RADIUS_DEF = 63;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 64;

  localparam logic [QUAD_W-1:0] QUAD_TL = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_TR = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_BL = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_BR = 3'd4;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [D_W-1:0]   dvar_t;

  // One arc command after classification.
  typedef struct packed {
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [RADIUS_W-1:0] r;
    logic                left;
    logic                top;
    logic [COLOR_W-1:0]  color;
  } cmd_t;

endpackage

FILE: rtl/core/qcr_front.sv
// Front end: accept arc commands, drop bad quadrants, clamp radius, decode mirroring.
module qcr_front #(
  parameter int MAX_RADIUS = qcr_pkg::MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [qcr_pkg::COORD_W-1:0]  in_cx,
  input  logic [qcr_pkg::COORD_W-1:0]  in_cy,
  input  logic [qcr_pkg::RADIUS_W-1:0] in_radius,
  input  logic [qcr_pkg::QUAD_W-1:0]   in_quad,
  input  logic [qcr_pkg::COLOR_W-1:0]  in_color,
  output logic                        push,
  output qcr_pkg::cmd_t               push_cmd,
  input  logic                        queue_full
);
  import qcr_pkg::*;

  logic              cmd_valid;
  cmd_t              cmd;
  cmd_t              cmd_next;
  logic              quad_ok;
  logic [RADIUS_W-1:0] r_sat;

  assign push     = cmd_valid && !queue_full;
  assign in_ready = !cmd_valid || !queue_full;
  assign push_cmd = cmd;

  always_comb begin
    quad_ok = 1'b1;
    cmd_next.left = 1'b0;
    cmd_next.top  = 1'b0;
    unique case (in_quad)
      QUAD_TL: begin
        cmd_next.left = 1'b1;
        cmd_next.top  = 1'b1;
      end
      QUAD_TR: begin
        cmd_next.top  = 1'b1;
      end
      QUAD_BL: begin
        cmd_next.left = 1'b1;
      end
      QUAD_BR: begin
        quad_ok = 1'b1;
      end
      default: begin
        quad_ok = 1'b0;
      end
    endcase
    if (int'(in_radius) > MAX_RADIUS) begin
      r_sat = RADIUS_W'(MAX_RADIUS);
    end else begin
      r_sat = in_radius;
    end
    cmd_next.cx    = in_cx;
    cmd_next.cy    = in_cy;
    cmd_next.r     = r_sat;
    cmd_next.color = in_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid && quad_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: rtl/core/qcr_queue.sv
// Short command queue between the front end and the arc walker.
module qcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  qcr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output qcr_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import qcr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/qcr_walker.sv
// Back end: Bresenham circle walk, quadrant mirroring and output register.
module qcr_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         queue_empty,
  input  qcr_pkg::cmd_t                queue_cmd,
  output logic                         pop,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [qcr_pkg::M_TDATA_W-1:0] m_data,
  output logic                         m_last
);
  import qcr_pkg::*;

  logic  busy;
  cmd_t  cmd;
  pos_t  x;
  pos_t  y;
  dvar_t d;

  pos_t  x_next;
  pos_t  y_next;
  dvar_t d_next;
  logic  step;
  logic  last;
  logic [COORD_W-1:0] off_x;
  logic [COORD_W-1:0] off_y;
  logic [COORD_W-1:0] first_x;
  logic [COORD_W-1:0] first_y;
  logic [COORD_W-1:0] second_x;
  logic [COORD_W-1:0] second_y;

  assign pop  = !busy && !queue_empty;
  assign step = busy && (!m_valid || m_ready);

  always_comb begin
    x_next = x + pos_t'(1);
    if (d > dvar_t'(0)) begin
      y_next = y - pos_t'(1);
      d_next = d + (dvar_t'(x_next - y_next) <<< 2) + dvar_t'(10);
    end else begin
      y_next = y;
      d_next = d + (dvar_t'(x_next) <<< 2) + dvar_t'(6);
    end
    last = (y_next < x_next);

    off_x = COORD_W'(x);
    off_y = COORD_W'(y);
    first_x  = cmd.left ? cmd.cx - off_x : cmd.cx + off_x;
    first_y  = cmd.top  ? cmd.cy - off_y : cmd.cy + off_y;
    second_x = cmd.left ? cmd.cx - off_y : cmd.cx + off_y;
    second_y = cmd.top  ? cmd.cy - off_x : cmd.cy + off_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (step && last) begin
        busy <= 1'b0;
      end
      if (step) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= queue_cmd;
      x   <= '0;
      y   <= pos_t'(queue_cmd.r);
      d   <= dvar_t'(3) - dvar_t'({queue_cmd.r, 1'b0});
    end else if (step) begin
      x <= x_next;
      y <= y_next;
      d <= d_next;
    end
    if (step) begin
      m_data <= {cmd.color, second_y, second_x, first_y, first_x};
      m_last <= last;
    end
  end

endmodule

FILE: rtl/core/quarter_circle_rasterizer_unit.sv
// Top level of the quarter-circle rasterizer: front end, command queue and arc walker.
//
// Usage
//   Slave channel (s_*): one beat carries one arc command. s_tdata holds the centre,
//   radius and colour; s_tuser holds the quadrant (1 top-left, 2 top-right,
//   3 bottom-left, 4 bottom-right). Commands with any other quadrant are dropped.
//   Master channel (m_*): one beat per walk step, carrying the two mirrored pixels
//   and the colour; m_tlast marks the final pair of each arc.
//   Radii above MAX_RADIUS clamp to MAX_RADIUS; coordinates wrap at 12 bits.
// Timing
//   A command passes through the front end's holding register and the queue before
//   the walker loads it; each pair is then registered at the output. Unless m_tready
//   stalls it, the walker issues one pair per cycle: about 0.71 * radius + 1 pairs
//   per arc (45 at radius 63), plus a gap while the next command is loaded from the
//   queue. The walker's single decision-variable update per cycle sets this rate.
// Reset and stalls
//   rst (synchronous) empties the queue and drops any arc in progress. While
//   m_tready is low the output beat holds and the walk pauses; the front end keeps
//   taking commands until its holding register and the two-entry queue are full.
module quarter_circle_rasterizer_unit #(
  parameter int MAX_RADIUS = qcr_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, lowest bit up: center_x[11:0], center_y[23:12], radius[29:24],
  // pen_color[45:30], zero padding[47:46]
  input  logic [qcr_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: quadrant[2:0]
  input  logic [qcr_pkg::QUAD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, lowest bit up: first_x[11:0], first_y[23:12], second_x[35:24],
  // second_y[47:36], pixel_color[63:48]
  output logic [qcr_pkg::M_TDATA_W-1:0]  m_tdata,
  // m_tlast: last_pair
  output logic                          m_tlast
);
  import qcr_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic queue_empty;
  logic pop;
  cmd_t pop_cmd;

  // Classify the command and hold it until the queue has room.
  qcr_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cx      (s_tdata[COORD_W-1:0]),
    .in_cy      (s_tdata[2*COORD_W-1:COORD_W]),
    .in_radius  (s_tdata[2*COORD_W+RADIUS_W-1:2*COORD_W]),
    .in_quad    (s_tuser),
    .in_color   (s_tdata[2*COORD_W+RADIUS_W+COLOR_W-1:2*COORD_W+RADIUS_W]),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  // Decouple command intake from the walk.
  qcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (queue_empty)
  );

  // Walk the arc and emit one beat per step.
  qcr_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_cmd   (pop_cmd),
    .pop         (pop),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .m_data      (m_tdata),
    .m_last      (m_tlast)
  );

endmodule
